FILE: sv/pdwa_pkg.sv
// pdwa_pkg: shared constants, configuration layout, sequencer types
// for the pixel demux window averager. no dependencies.
package pdwa_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COUNT_BITS     = 20;
  localparam int SLOT_BITS      = 13;
  localparam int OFFSET_BITS    = 12;
  localparam int WAVE_BITS      = 8;
  localparam int COEF_BITS      = 32;
  localparam int VALUE_BITS     = 48;
  localparam int SUM_BITS       = SAMPLE_BITS + SLOT_BITS;
  localparam int PROD_BITS      = SUM_BITS + COEF_BITS;
  localparam int TOTAL_BITS     = PROD_BITS + 1;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int DIV_CNT_BITS   = $clog2(SUM_BITS + 1);
  localparam int SLOT_MAX       = 4096;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_SKIP,
    REG_FRAME_SIZE,
    REG_SLOT_LENGTH,
    REG_SLOT_COUNT,
    REG_WINDOW_OFFSET,
    REG_WINDOW_LENGTH,
    REG_GAIN,
    REG_BIAS
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  start_skip;
    logic [COUNT_BITS-1:0]  frame_size;
    logic [SLOT_BITS-1:0]   slot_length;
    logic [COUNT_BITS-1:0]  slot_count;
    logic [OFFSET_BITS-1:0] window_offset;
    logic [SLOT_BITS-1:0]   window_length;
    logic [COEF_BITS-1:0]   gain;
    logic [COEF_BITS-1:0]   bias;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic div_start;
    logic mul_en;
    logic add_en;
    logic out_load;
  } seq_ctl_t;

  typedef struct packed {
    logic [WAVE_BITS-1:0]  wave;
    logic [COUNT_BITS-1:0] pixel;
    logic [COUNT_BITS-1:0] frame;
  } tag_t;

endpackage

FILE: sv/pixel_demux_window_averager_core.sv
// Pixel demux window averager. Samples enter on the input channel (in_valid,
// in_stall, sample, wave_start); wave_start opens a waveform and restarts the
// skip, frame and slot counters. After start_skip samples each frame is cut
// into slots, and the last sample of each slot's window yields one result
// beat on the output channel (out_valid, out_stall, value and indices).
// Configuration is written through cfg_we / cfg_index / cfg_data while idle
// (the user's duty, not enforced by the core). A sample that closes a window
// runs the shared divider (one quotient bit a cycle, then the sign fix), then
// multiply and bias/saturate steps; its result is loaded into the output
// register before the next sample is taken. in_stall is high from the cycle
// after such a sample until its result is written into the output register.
// A result held by out_stall does not block samples that close no window;
// the next result waits in its final step until the output register frees
// up. Reset (rst, synchronous) clears the counters, the sequencer and
// out_valid and restores register defaults.
// depends on pdwa_pkg, pdwa_seq, pdwa_div, pdwa_scale
module pixel_demux_window_averager_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [pdwa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pdwa_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pdwa_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                    wave_start,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pdwa_pkg::VALUE_BITS-1:0]  value,
  output logic [pdwa_pkg::WAVE_BITS-1:0]          wave_index,
  output logic [pdwa_pkg::COUNT_BITS-1:0]         pixel_index,
  output logic [pdwa_pkg::COUNT_BITS-1:0]         frame_index
);
  import pdwa_pkg::*;

  cfg_t                       cfg;
  seq_ctl_t                   ctl;
  tag_t                       tag;
  logic                       out_free;
  logic                       div_done;
  logic signed [SUM_BITS-1:0] dividend;
  logic signed [SUM_BITS-1:0] quotient;
  logic [VALUE_BITS-1:0]      scaled;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_skip    <= '0;
      cfg.frame_size    <= COUNT_BITS'(1024);
      cfg.slot_length   <= SLOT_BITS'(4);
      cfg.slot_count    <= COUNT_BITS'(256);
      cfg.window_offset <= OFFSET_BITS'(1);
      cfg.window_length <= SLOT_BITS'(2);
      cfg.gain          <= COEF_BITS'(65536);
      cfg.bias          <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_SKIP:    cfg.start_skip    <= cfg_data[COUNT_BITS-1:0];
        REG_FRAME_SIZE:    cfg.frame_size    <= cfg_data[COUNT_BITS-1:0];
        REG_SLOT_LENGTH:   cfg.slot_length   <= cfg_data[SLOT_BITS-1:0];
        REG_SLOT_COUNT:    cfg.slot_count    <= cfg_data[COUNT_BITS-1:0];
        REG_WINDOW_OFFSET: cfg.window_offset <= cfg_data[OFFSET_BITS-1:0];
        REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[SLOT_BITS-1:0];
        REG_GAIN:          cfg.gain          <= cfg_data[COEF_BITS-1:0];
        REG_BIAS:          cfg.bias          <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  pdwa_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .wave_start (wave_start),
    .out_free   (out_free),
    .div_done   (div_done),
    .ctl        (ctl),
    .dividend   (dividend),
    .tag        (tag)
  );

  pdwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (cfg.window_length),
    .done     (div_done),
    .quotient (quotient)
  );

  pdwa_scale u_scale (
    .clk      (clk),
    .mul_en   (ctl.mul_en),
    .add_en   (ctl.add_en),
    .quotient (quotient),
    .gain     (cfg.gain),
    .bias     (cfg.bias),
    .scaled   (scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      value       <= signed'(scaled);
      wave_index  <= tag.wave;
      pixel_index <= tag.pixel;
      frame_index <= tag.frame;
    end
  end

endmodule

FILE: sv/pdwa_div.sv
// pdwa_div: iterative signed divider, one quotient bit per cycle,
// then a sign fix step. depends on pdwa_pkg.
module pdwa_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pdwa_pkg::SUM_BITS-1:0] dividend,
  input  logic [pdwa_pkg::SLOT_BITS-1:0]       divisor,
  output logic                                 done,
  output logic signed [pdwa_pkg::SUM_BITS-1:0] quotient
);
  import pdwa_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    neg;
  logic [SUM_BITS-1:0]     quo;
  logic [SLOT_BITS-1:0]    rem;
  logic [SLOT_BITS:0]      trial;
  logic                    fits;
  logic [SLOT_BITS-1:0]    rem_next;
  logic [SUM_BITS-1:0]     quo_next;
  logic [SUM_BITS-1:0]     mag;

  assign mag      = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
  assign trial    = {rem, quo[SUM_BITS-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_next = fits ? SLOT_BITS'(trial - {1'b0, divisor}) : trial[SLOT_BITS-1:0];
  assign quo_next = {quo[SUM_BITS-2:0], fits};
  assign quotient = signed'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(SUM_BITS);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_BITS-1];
      quo <= mag;
      rem <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        quo <= quo_next;
        rem <= rem_next;
      end else if (neg) begin
        // restore the sign, truncation toward zero
        quo <= SUM_BITS'(-quo);
      end
    end
  end

endmodule

FILE: sv/pdwa_scale.sv
// pdwa_scale: gain multiply and bias add with 48 bit saturation,
// one register per step. depends on pdwa_pkg.
module pdwa_scale (
  input  logic                                   clk,
  input  logic                                   mul_en,
  input  logic                                   add_en,
  input  logic signed [pdwa_pkg::SUM_BITS-1:0]   quotient,
  input  logic [pdwa_pkg::COEF_BITS-1:0]         gain,
  input  logic [pdwa_pkg::COEF_BITS-1:0]         bias,
  output logic [pdwa_pkg::VALUE_BITS-1:0]        scaled
);
  import pdwa_pkg::*;

  logic signed [PROD_BITS-1:0]  product;
  logic signed [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-VALUE_BITS:0] upper;
  logic                         in_range;

  assign total    = TOTAL_BITS'(product) + TOTAL_BITS'(signed'(bias));
  assign upper    = total[TOTAL_BITS-1:VALUE_BITS-1];
  assign in_range = (&upper) || ~(|upper);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      product <= PROD_BITS'(quotient) * PROD_BITS'(signed'(gain));
    end
    if (add_en) begin
      if (in_range) begin
        scaled <= total[VALUE_BITS-1:0];
      end else begin
        scaled <= total[TOTAL_BITS-1] ? VALUE_MIN : VALUE_MAX;
      end
    end
  end

endmodule

FILE: sv/pdwa_seq.sv
// pdwa_seq: waveform, frame and slot counters, window sum and the
// sequencer that steps the divider and scaler. depends on pdwa_pkg.
module pdwa_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pdwa_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pdwa_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  wave_start,
  input  logic                                  out_free,
  input  logic                                  div_done,
  output pdwa_pkg::seq_ctl_t                    ctl,
  output logic signed [pdwa_pkg::SUM_BITS-1:0]  dividend,
  output pdwa_pkg::tag_t                        tag
);
  import pdwa_pkg::*;

  seq_state_t state, state_next;

  logic                       opened;
  logic [WAVE_BITS-1:0]       wave_number;
  logic [COUNT_BITS-1:0]      skip_left;
  logic [COUNT_BITS-1:0]      frame_pos;
  logic [OFFSET_BITS-1:0]     slot_pos;
  logic [COUNT_BITS-1:0]      slot_index;
  logic [COUNT_BITS-1:0]      frame_number;
  logic signed [SUM_BITS-1:0] window_sum;

  logic                       opened_next;
  logic [WAVE_BITS-1:0]       wave_number_next;
  logic [COUNT_BITS-1:0]      skip_left_next;
  logic [COUNT_BITS-1:0]      frame_pos_next;
  logic [OFFSET_BITS-1:0]     slot_pos_next;
  logic [COUNT_BITS-1:0]      slot_index_next;
  logic [COUNT_BITS-1:0]      frame_number_next;
  logic signed [SUM_BITS-1:0] window_sum_next;

  // counter values after an optional waveform restart
  logic [COUNT_BITS-1:0]      skip_b;
  logic [COUNT_BITS-1:0]      fpos_b;
  logic [OFFSET_BITS-1:0]     spos_b;
  logic [COUNT_BITS-1:0]      sidx_b;
  logic [COUNT_BITS-1:0]      fnum_b;
  logic signed [SUM_BITS-1:0] sum_b;

  logic                       accept;
  logic                       emit;
  logic                       active;
  logic                       in_win;
  logic                       win_last;
  logic [OFFSET_BITS-1:0]     win_diff;
  logic [SLOT_BITS-1:0]       slen_eff;
  logic [SLOT_BITS-1:0]       spos_inc;
  logic [COUNT_BITS-1:0]      fpos_inc;
  logic signed [SUM_BITS-1:0] sum_add;

  assign accept   = in_valid && !in_stall;
  assign dividend = sum_add;

  assign slen_eff = (cfg.slot_length == '0 || cfg.slot_length > SLOT_BITS'(SLOT_MAX))
                    ? SLOT_BITS'(SLOT_MAX) : cfg.slot_length;

  always_comb begin
    wave_number_next = wave_number;
    skip_b = skip_left;
    fpos_b = frame_pos;
    spos_b = slot_pos;
    sidx_b = slot_index;
    fnum_b = frame_number;
    sum_b  = window_sum;
    if (wave_start) begin
      if (opened) begin
        wave_number_next = wave_number + 1'b1;
      end
      skip_b = cfg.start_skip;
      fpos_b = '0;
      spos_b = '0;
      sidx_b = '0;
      fnum_b = '0;
      sum_b  = '0;
    end
    opened_next = opened | wave_start;

    active   = sidx_b < cfg.slot_count;
    win_diff = spos_b - cfg.window_offset;
    in_win   = (spos_b >= cfg.window_offset) &&
               ({1'b0, win_diff} < cfg.window_length);
    win_last = {1'b0, win_diff} == SLOT_BITS'(cfg.window_length - 1'b1);
    sum_add  = sum_b + SUM_BITS'(sample);
    spos_inc = {1'b0, spos_b} + 1'b1;
    fpos_inc = fpos_b + 1'b1;

    skip_left_next    = skip_b;
    frame_pos_next    = fpos_b;
    slot_pos_next     = spos_b;
    slot_index_next   = sidx_b;
    frame_number_next = fnum_b;
    window_sum_next   = sum_b;
    emit              = 1'b0;

    if (opened_next) begin
      if (skip_b != '0) begin
        skip_left_next = skip_b - 1'b1;
      end else begin
        if (active) begin
          if (in_win) begin
            window_sum_next = sum_add;
            if (win_last) begin
              emit            = 1'b1;
              window_sum_next = '0;
            end
          end
          if (spos_inc >= slen_eff) begin
            slot_pos_next   = '0;
            slot_index_next = sidx_b + 1'b1;
            window_sum_next = '0;
          end else begin
            slot_pos_next = spos_inc[OFFSET_BITS-1:0];
          end
        end
        frame_pos_next = fpos_inc;
        if (fpos_inc == cfg.frame_size) begin
          frame_pos_next    = '0;
          slot_pos_next     = '0;
          slot_index_next   = '0;
          window_sum_next   = '0;
          frame_number_next = fnum_b + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      opened       <= 1'b0;
      wave_number  <= '0;
      skip_left    <= '0;
      frame_pos    <= '0;
      slot_pos     <= '0;
      slot_index   <= '0;
      frame_number <= '0;
      window_sum   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        opened       <= opened_next;
        wave_number  <= wave_number_next;
        skip_left    <= skip_left_next;
        frame_pos    <= frame_pos_next;
        slot_pos     <= slot_pos_next;
        slot_index   <= slot_index_next;
        frame_number <= frame_number_next;
        window_sum   <= window_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      tag.wave  <= wave_number_next;
      tag.pixel <= sidx_b;
      tag.frame <= fnum_b;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && emit) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ctl.div_start = 1'b0;
    ctl.mul_en    = 1'b0;
    ctl.add_en    = 1'b0;
    ctl.out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        ctl.div_start = in_valid && emit;
      end
      ST_DIV:  ;
      ST_MUL:  ctl.mul_en = 1'b1;
      ST_ADD:  ctl.add_en = 1'b1;
      ST_OUT:  ctl.out_load = out_free;
      default: ;
    endcase
  end

endmodule

FILE: sv/pdwa_checker.sv
// pdwa_checker: port level checks on the averager core, bound to the top.
// depends on pdwa_pkg and pixel_demux_window_averager_core.
module pdwa_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [pdwa_pkg::VALUE_BITS-1:0]  value,
  input logic [pdwa_pkg::COUNT_BITS-1:0]         pixel_index
);
  import pdwa_pkg::*;

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(pixel_index))
    else $error("stalled output beat changed");

  // a new result is loaded only from the final step, where the input is held off
  a_no_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_stall |=> !out_valid)
    else $error("output beat loaded while the sequencer was idle");

  // a new result appears only while the input side was held off
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(in_stall))
    else $error("result appeared without a busy sequencer");

endmodule

bind pixel_demux_window_averager_core pdwa_checker u_pdwa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .value       (value),
  .pixel_index (pixel_index)
);

FILE: tb/pixel_demux_window_averager_core_tb.sv
`timescale 1ns / 1ps
// pixel_demux_window_averager_core_tb: feeds sample beats and register writes to the core,
// predicts every pixel average and checks output beats in order
// depends on pdwa_pkg and pixel_demux_window_averager_core

import pdwa_pkg::*;

typedef struct {
  logic signed [VALUE_BITS-1:0] value;
  logic [WAVE_BITS-1:0]         wave;
  logic [COUNT_BITS-1:0]        pixel;
  logic [COUNT_BITS-1:0]        frame;
} pixel_beat_t;

class pixel_scoreboard;
  logic [COUNT_BITS-1:0]       skip_cfg, frame_cfg, count_cfg;
  logic [SLOT_BITS-1:0]        slot_len_cfg, win_len_cfg;
  logic [OFFSET_BITS-1:0]      win_off_cfg;
  logic signed [COEF_BITS-1:0] gain_cfg, bias_cfg;

  logic [COUNT_BITS-1:0]       skip_left, frame_pos, slot_index, frame_num;
  logic [SLOT_BITS-1:0]        slot_pos;
  logic [WAVE_BITS-1:0]        wave_num;
  longint                      window_sum;
  bit                          opened;

  pixel_beat_t                 expected_pixels[$];
  int                          errors;

  function new();
    skip_cfg     = '0;
    frame_cfg    = COUNT_BITS'(1024);
    slot_len_cfg = SLOT_BITS'(4);
    count_cfg    = COUNT_BITS'(256);
    win_off_cfg  = OFFSET_BITS'(1);
    win_len_cfg  = SLOT_BITS'(2);
    gain_cfg     = COEF_BITS'(65536);
    bias_cfg     = '0;
    skip_left    = '0;
    frame_pos    = '0;
    slot_index   = '0;
    frame_num    = '0;
    slot_pos     = '0;
    wave_num     = '0;
    window_sum   = 0;
    opened       = 1'b0;
    errors       = 0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_START_SKIP:    skip_cfg     = data[COUNT_BITS-1:0];
      REG_FRAME_SIZE:    frame_cfg    = data[COUNT_BITS-1:0];
      REG_SLOT_LENGTH:   slot_len_cfg = data[SLOT_BITS-1:0];
      REG_SLOT_COUNT:    count_cfg    = data[COUNT_BITS-1:0];
      REG_WINDOW_OFFSET: win_off_cfg  = data[OFFSET_BITS-1:0];
      REG_WINDOW_LENGTH: win_len_cfg  = data[SLOT_BITS-1:0];
      REG_GAIN:          gain_cfg     = data[COEF_BITS-1:0];
      REG_BIAS:          bias_cfg     = data[COEF_BITS-1:0];
      default: ;
    endcase
  endfunction

  // advance the demux state by one accepted sample, queue the pixel it closes
  function void note_sample(logic signed [SAMPLE_BITS-1:0] s, logic mark);
    int          slen;
    int          rel;
    longint      avg;
    longint      scaled;
    longint      hi;
    longint      lo;
    pixel_beat_t beat;
    hi = longint'($signed(VALUE_MAX));
    lo = longint'($signed(VALUE_MIN));
    if (mark) begin
      if (opened) wave_num++;
      opened     = 1'b1;
      skip_left  = skip_cfg;
      frame_pos  = '0;
      slot_pos   = '0;
      slot_index = '0;
      frame_num  = '0;
      window_sum = 0;
    end
    if (!opened) return;
    if (skip_left != 0) begin
      skip_left--;
      return;
    end
    slen = (slot_len_cfg == 0 || slot_len_cfg > SLOT_MAX) ? SLOT_MAX : int'(slot_len_cfg);
    if (slot_index < count_cfg) begin
      rel = int'(slot_pos) - int'(win_off_cfg);
      if (rel >= 0 && rel < int'(win_len_cfg)) begin
        window_sum += longint'(s);
        if (rel == int'(win_len_cfg) - 1) begin
          // truncating divide, then affine scale in q16.16
          avg    = window_sum / longint'(win_len_cfg);
          scaled = avg * longint'(gain_cfg) + longint'(bias_cfg);
          if (scaled > hi) scaled = hi;
          if (scaled < lo) scaled = lo;
          beat.value = scaled[VALUE_BITS-1:0];
          beat.wave  = wave_num;
          beat.pixel = slot_index;
          beat.frame = frame_num;
          expected_pixels.push_back(beat);
          window_sum = 0;
        end
      end
      slot_pos++;
      if (int'(slot_pos) >= slen) begin
        slot_pos   = '0;
        slot_index++;
        window_sum = 0;
      end
    end
    frame_pos++;
    if (frame_pos == frame_cfg) begin
      frame_pos  = '0;
      slot_pos   = '0;
      slot_index = '0;
      window_sum = 0;
      frame_num++;
    end
  endfunction

  function void check_result(logic signed [VALUE_BITS-1:0] value, logic [WAVE_BITS-1:0] wave,
                             logic [COUNT_BITS-1:0] pixel, logic [COUNT_BITS-1:0] frame);
    pixel_beat_t want;
    if (expected_pixels.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none, got value %0d wave %0d pixel %0d frame %0d",
               $time, value, wave, pixel, frame);
      return;
    end
    want = expected_pixels.pop_front();
    if (value !== want.value) begin
      errors++;
      $display("%0t: value expected %0d, got %0d", $time, want.value, value);
    end
    if (wave !== want.wave) begin
      errors++;
      $display("%0t: wave_index expected %0d, got %0d", $time, want.wave, wave);
    end
    if (pixel !== want.pixel) begin
      errors++;
      $display("%0t: pixel_index expected %0d, got %0d", $time, want.pixel, pixel);
    end
    if (frame !== want.frame) begin
      errors++;
      $display("%0t: frame_index expected %0d, got %0d", $time, want.frame, frame);
    end
  endfunction
endclass

module pixel_demux_window_averager_core_tb;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [CFG_INDEX_BITS-1:0]       cfg_index;
  logic [CFG_DATA_BITS-1:0]        cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic signed [SAMPLE_BITS-1:0]   sample;
  logic                            wave_start;
  logic                            out_valid;
  logic                            out_stall;
  logic signed [VALUE_BITS-1:0]    value;
  logic [WAVE_BITS-1:0]            wave_index;
  logic [COUNT_BITS-1:0]           pixel_index;
  logic [COUNT_BITS-1:0]           frame_index;

  bit                              hold_req   = 1'b0;
  bit                              quiet_tail = 1'b0;
  pixel_scoreboard                 sb;

  // default config: slots of 4, window at positions 1..2
  logic signed [SAMPLE_BITS-1:0] dir_sample [18] = '{
    100, -5, 0, -32768, -32768, 7, 5, 32767, 32767, 1, 9, -1, -2, 3, 3, -4, 0, 12
  };
  logic dir_mark [18] = '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0};

  pixel_demux_window_averager_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .wave_start  (wave_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .wave_index  (wave_index),
    .pixel_index (pixel_index),
    .frame_index (frame_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(value, wave_index, pixel_index, frame_index);
  end

  // output side: random stall bursts, one long hold-off, none at the tail
  initial begin : receiver
    bit held;
    bit stall_v;
    int span;
    held = 1'b0;
    forever begin
      if (quiet_tail) begin
        stall_v = 1'b0;
        span    = 1;
      end else if (hold_req && !held) begin
        held    = 1'b1;
        stall_v = 1'b1;
        span    = HOLD_CYCLES;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            stall_v = 1'b1;
            span    = $urandom_range(1, 16);
          end
          1: begin
            stall_v = 1'b0;
            span    = $urandom_range(1, 16);
          end
          default: begin
            stall_v = 1'b0;
            span    = $urandom_range(16, 64);
          end
        endcase
      end
      out_stall <= stall_v;
      repeat (span) @(posedge clk);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data,
                           input bit scramble);
    int                       width;
    logic [CFG_DATA_BITS-1:0] junk;
    case (idx)
      REG_SLOT_LENGTH, REG_WINDOW_LENGTH: width = SLOT_BITS;
      REG_WINDOW_OFFSET:                  width = OFFSET_BITS;
      REG_GAIN, REG_BIAS:                 width = COEF_BITS;
      default:                            width = COUNT_BITS;
    endcase
    junk = $urandom();
    // unused upper bits must be ignored
    if (scramble && width < CFG_DATA_BITS) data = data | (junk << width);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] skip, frame, slen, count, offset, wlen,
                            gain, bias, input bit scramble);
    write_reg(REG_START_SKIP, skip, scramble);
    write_reg(REG_FRAME_SIZE, frame, scramble);
    write_reg(REG_SLOT_LENGTH, slen, scramble);
    write_reg(REG_SLOT_COUNT, count, scramble);
    write_reg(REG_WINDOW_OFFSET, offset, scramble);
    write_reg(REG_WINDOW_LENGTH, wlen, scramble);
    write_reg(REG_GAIN, gain, scramble);
    write_reg(REG_BIAS, bias, scramble);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic mark);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample     <= s;
    wave_start <= mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, mark);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_BITS'(-32768);
      1:       return SAMPLE_BITS'(32767);
      2:       return SAMPLE_BITS'(0);
      3:       return SAMPLE_BITS'(-1);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic send_burst(input int n, input int mark_pct, input bit open_wave);
    logic mark;
    for (int i = 0; i < n; i++) begin
      mark = (i == 0 && open_wave) || ($urandom_range(0, 99) < mark_pct);
      send_sample(pick_sample(), mark);
    end
  endtask

  // wait out all pending pixels plus the pipeline of trailing samples
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int slen;
    int cnt;
    int off;
    int wlen;
    slen = $urandom_range(1, 6);
    cnt  = $urandom_range(1, 6);
    off  = $urandom_range(0, slen - 1);
    if ($urandom_range(0, 4) == 0) wlen = $urandom_range(0, slen + 1);
    else wlen = $urandom_range(1, slen - off);
    set_config($urandom_range(0, 4), $urandom_range(1, slen * cnt + 4), slen, cnt, off, wlen,
               $urandom(), $urandom(), 1'b1);
    send_burst(n, 4, 1'b1);
    drain();
  endtask

  initial begin : stimulus
    sb = new();
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_START_SKIP;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    sample     <= '0;
    wave_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config, samples before the first mark, extremes, truncation toward zero
    foreach (dir_sample[i]) send_sample(dir_sample[i], dir_mark[i]);
    drain();

    // skip, idle tail of frame, negative gain, max bias; output held off meanwhile
    hold_req <= 1'b1;
    set_config(2, 10, 3, 3, 0, 3, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0);
    send_burst(40, 3, 1'b1);
    drain();

    // no slots at all
    set_config(0, 12, 4, 0, 1, 2, 32'h0001_0000, 0, 1'b0);
    send_burst(12, 10, 1'b1);
    drain();

    // window past the slot end, then empty window
    set_config(1, 16, 4, 4, 3, 2, 32'h0001_0000, 100, 1'b0);
    send_burst(12, 5, 1'b1);
    drain();
    set_config(0, 16, 4, 4, 2, 0, 32'h0001_0000, 100, 1'b0);
    send_burst(12, 5, 1'b1);
    drain();

    // frame of 7 cuts the third slot short; most negative coefficients
    set_config(0, 7, 3, 5, 1, 2, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_burst(20, 5, 1'b1);
    drain();

    // max skip only loads on a mark, so the open waveform keeps running
    set_config(20'hFFFFF, 7, 3, 5, 1, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_burst(12, 0, 1'b0);
    drain();

    // slot length zero acts as 4096, frame size zero, window near the slot start
    set_config(0, 0, 0, 20'hFFFFF, 3, 4, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
    send_burst(20, 0, 1'b1);
    drain();

    // oversize slot length acts as 4096
    set_config(0, 20'hFFFFF, 8191, 1, 10, 3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_burst(20, 0, 1'b1);
    drain();

    // a mark on every beat to wrap the wave index
    set_config(0, 5, 1, 5, 0, 1, $urandom(), $urandom(), 1'b0);
    send_burst(250, 100, 1'b1);
    drain();

    repeat (2) random_phase(15);

    quiet_tail <= 1'b1;
    random_phase(15);

    if (sb.errors == 0)
      $display("** pixel_demux_window_averager_core: PASSED **");
    else
      $display("** pixel_demux_window_averager_core: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;  // 10 ms
    $display("** pixel_demux_window_averager_core: FAILED **");
    $finish;
  end
endmodule
